/* sv/zrr_pkg.sv */
`default_nettype none
package zrr_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int SYM_W  = 8;
  localparam int CNT_W  = 7;   // holds counts up to the largest depth (64)
  localparam int RAIL_W = 7;
  localparam int POS_W  = 9;   // position plus a period of up to 252

  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic              ovf;
    logic [RAIL_W-1:0] rails;
  } desc_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             eob;
    logic             ovf;
  } out_item_t;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

/* sv/zrr_store.sv */
`default_nettype none
module zrr_store #(
  parameter int STORE_DEPTH = zrr_pkg::STORE_DEPTH_DEF,
  parameter int AW = $clog2(STORE_DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [zrr_pkg::SYM_W-1:0] wr_data,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic      [zrr_pkg::SYM_W-1:0] rd_data
);
  import zrr_pkg::*;

  logic [SYM_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* sv/zrr_desc_fifo.sv */
`default_nettype none
module zrr_desc_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire zrr_pkg::desc_t push_data,
  output logic                full,
  input  wire logic           pop,
  output zrr_pkg::desc_t      pop_data,
  output logic                empty
);
  import zrr_pkg::*;

  desc_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

/* sv/zrr_front.sv */
`default_nettype none
module zrr_front #(
  parameter int STORE_DEPTH = zrr_pkg::STORE_DEPTH_DEF,
  parameter int AW = $clog2(STORE_DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [zrr_pkg::RAIL_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [zrr_pkg::SYM_W-1:0]  symbol,
  input  wire logic                       final_symbol,
  output logic                            wr_en,
  output logic      [AW-1:0]              wr_addr,
  output logic      [zrr_pkg::SYM_W-1:0]  wr_data,
  output logic                            desc_push,
  output zrr_pkg::desc_t                  desc,
  input  wire logic                       desc_full,
  input  wire logic                       block_done
);
  import zrr_pkg::*;

  logic [RAIL_W-1:0] rail_count;
  logic [CNT_W-1:0]  fill_count;
  logic              overflow_seen;
  logic              busy;           // a block is out for emission
  logic              accept;
  logic              room;

  assign in_stall = busy || desc_full;
  assign accept   = in_valid && !in_stall;
  assign room     = (fill_count < CNT_W'(STORE_DEPTH));

  assign wr_en   = accept && room;
  assign wr_addr = fill_count[AW-1:0];
  assign wr_data = symbol;

  assign desc_push  = accept && final_symbol;
  assign desc.n     = room ? fill_count + 1'b1 : fill_count;
  assign desc.ovf   = overflow_seen || !room;
  assign desc.rails = (rail_count == '0) ? RAIL_W'(1) : rail_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      rail_count    <= RAIL_W'(1);
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      busy          <= 1'b0;
    end else begin
      if (cfg_wen) begin
        rail_count <= cfg_wdata;
      end
      if (desc_push) begin
        fill_count    <= '0;
        overflow_seen <= 1'b0;
        busy          <= 1'b1;
      end else begin
        if (accept && room) begin
          fill_count <= fill_count + 1'b1;
        end
        if (accept && !room) begin
          overflow_seen <= 1'b1;
        end
        if (block_done) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sv/zrr_back.sv */
`default_nettype none
module zrr_back #(
  parameter int STORE_DEPTH = zrr_pkg::STORE_DEPTH_DEF,
  parameter int AW = $clog2(STORE_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      desc_empty,
  input  wire zrr_pkg::desc_t            desc,
  output logic                           desc_pop,
  output logic                           rd_en,
  output logic     [AW-1:0]              rd_addr,
  input  wire logic [zrr_pkg::SYM_W-1:0] rd_data,
  output logic                           block_done,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic     [zrr_pkg::SYM_W-1:0]  out_symbol,
  output logic                           end_of_block,
  output logic                           overflowed
);
  import zrr_pkg::*;

  back_state_t       state, state_next;
  desc_t             cur, cur_next;
  logic [RAIL_W-1:0] row, row_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic              phase, phase_next;   // 1: partner slot of a middle rail
  logic [CNT_W-1:0]  emit_cnt, emit_cnt_next;

  logic [POS_W-1:0]  period, step, partner, cand;
  logic              hit, middle, last, issue, room, pop_out;
  logic [1:0]        occ;

  // read pipeline and output buffer
  logic              inflight;
  logic              rd_eob, rd_ovf;
  out_item_t         obuf [2];
  logic              ob_wr, ob_rd;
  logic [1:0]        ob_cnt;
  out_item_t         head;

  assign period  = POS_W'({cur.rails - 1'b1, 1'b0});
  assign step    = (cur.rails == RAIL_W'(1)) ? POS_W'(1) : period;
  assign partner = pos + period - POS_W'({row, 1'b0});
  assign cand    = phase ? partner : pos;
  assign hit     = (cand < POS_W'(cur.n));
  assign middle  = (row != '0) && (row != cur.rails - 1'b1);
  assign last    = (emit_cnt == cur.n - 1'b1);

  assign pop_out = out_valid && !out_stall;
  assign occ     = ob_cnt + 2'(inflight);
  assign room    = (occ < 2'd2) || pop_out;

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    row_next      = row;
    pos_next      = pos;
    phase_next    = phase;
    emit_cnt_next = emit_cnt;
    desc_pop      = 1'b0;
    issue         = 1'b0;
    block_done    = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!desc_empty) begin
          desc_pop      = 1'b1;
          cur_next      = desc;
          row_next      = '0;
          pos_next      = '0;
          phase_next    = 1'b0;
          emit_cnt_next = '0;
          state_next    = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!hit || room) begin
          if (hit) begin
            issue         = 1'b1;
            emit_cnt_next = emit_cnt + 1'b1;
            if (last) begin
              block_done = 1'b1;
              state_next = B_IDLE;
            end
          end
          priority if (phase) begin
            phase_next = 1'b0;
            pos_next   = pos + step;
          end else if (hit) begin
            if (middle) begin
              phase_next = 1'b1;
            end else begin
              pos_next = pos + step;
            end
          end else begin
            // rail exhausted, start the next one
            row_next = row + 1'b1;
            pos_next = POS_W'(row) + 1'b1;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign rd_en   = issue;
  assign rd_addr = cand[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      inflight <= 1'b0;
      ob_wr    <= 1'b0;
      ob_rd    <= 1'b0;
      ob_cnt   <= 2'd0;
    end else begin
      state    <= state_next;
      inflight <= issue;
      if (inflight) begin
        ob_wr <= ~ob_wr;
      end
      if (pop_out) begin
        ob_rd <= ~ob_rd;
      end
      ob_cnt <= ob_cnt + 2'(inflight) - 2'(pop_out);
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    row      <= row_next;
    pos      <= pos_next;
    phase    <= phase_next;
    emit_cnt <= emit_cnt_next;
    rd_eob   <= last;
    rd_ovf   <= cur.ovf;
    if (inflight) begin
      obuf[ob_wr] <= '{sym: rd_data, eob: rd_eob, ovf: rd_ovf};
    end
  end

  assign head         = obuf[ob_rd];
  assign out_valid    = (ob_cnt != 2'd0);
  assign out_symbol   = head.sym;
  assign end_of_block = head.eob;
  assign overflowed   = head.ovf;

endmodule
`default_nettype wire

/* sv/zigzag_rail_reorder.sv */
// Output path: once the final symbol is accepted, the first output byte passes the
//   descriptor pop, sequencer start, registered store read and output buffer.
// Throughput: loading takes 1 symbol per cycle while in_stall is low; emission gives
//   up to 1 byte per cycle while out_stall is low, pausing at each rail end and each
//   missing partner, all through the single read port of the symbol store.
// Reset: synchronous; clears fill count, overflow flag and queues, sets rails to 1.
`default_nettype none
module zigzag_rail_reorder #(
  parameter int STORE_DEPTH = zrr_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [zrr_pkg::RAIL_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [zrr_pkg::SYM_W-1:0]  symbol,
  input  wire logic                       final_symbol,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [zrr_pkg::SYM_W-1:0]  out_symbol,
  output logic                            end_of_block,
  output logic                            overflowed
);
  import zrr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [SYM_W-1:0] wr_data, rd_data;
  logic             desc_push, desc_pop, desc_full, desc_empty, block_done;
  desc_t            desc_in, desc_out;

  zrr_front #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .symbol       (symbol),
    .final_symbol (final_symbol),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .desc_push    (desc_push),
    .desc         (desc_in),
    .desc_full    (desc_full),
    .block_done   (block_done)
  );

  zrr_desc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_data (desc_in),
    .full      (desc_full),
    .pop       (desc_pop),
    .pop_data  (desc_out),
    .empty     (desc_empty)
  );

  zrr_store #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  zrr_back #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .desc_empty   (desc_empty),
    .desc         (desc_out),
    .desc_pop     (desc_pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .block_done   (block_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_symbol   (out_symbol),
    .end_of_block (end_of_block),
    .overflowed   (overflowed)
  );

endmodule
`default_nettype wire

/* sv/zrr_checker.sv */
`default_nettype none
module zrr_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      final_symbol,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [zrr_pkg::SYM_W-1:0] out_symbol
);
  import zrr_pkg::*;

  // nothing pending right after reset
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // a final transaction hands the store to emission, so input must hold off
  a_final_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_symbol |=> in_stall)
    else $error("input taken while block emits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_symbol))
    else $error("output symbol changed under stall");

endmodule

bind zigzag_rail_reorder zrr_checker u_zrr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .final_symbol (final_symbol),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_symbol   (out_symbol)
);
`default_nettype wire
